/* hw/rtl/kbh_pkg.sv */
// ----------------------------------------------------------------------------
// kbh_pkg
// Shared types, constants and SipRound helpers for the keyed bucket hash.
// ----------------------------------------------------------------------------
package kbh_pkg;

	localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
	localparam logic [63:0] SIP_C1 = 64'h646f6e646d61636b;
	localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
	localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
	localparam logic [63:0] MIX_M1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_M2 = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

	localparam logic [1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [1:0] REG_CAP_LOG2 = 2'd2;

	localparam logic [4:0] CAP_LOG2_RESET = 5'd5;
	localparam int         QUEUE_DEPTH    = 2;

	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
	} kbh_lanes_t;

	function automatic kbh_lanes_t sip_round(input kbh_lanes_t v);
		kbh_lanes_t r;
		r = v;
		r.v0 = r.v0 + r.v1;
		r.v2 = r.v2 + r.v3;
		r.v1 = {r.v1[50:0], r.v1[63:51]};
		r.v3 = {r.v3[47:0], r.v3[63:48]};
		r.v1 = r.v1 ^ r.v0;
		r.v3 = r.v3 ^ r.v2;
		r.v0 = {r.v0[31:0], r.v0[63:32]};
		r.v2 = r.v2 + r.v1;
		r.v0 = r.v0 + r.v3;
		r.v1 = {r.v1[46:0], r.v1[63:47]};
		r.v3 = {r.v3[42:0], r.v3[63:43]};
		r.v1 = r.v1 ^ r.v2;
		r.v3 = r.v3 ^ r.v0;
		r.v2 = {r.v2[31:0], r.v2[63:32]};
		return r;
	endfunction

	function automatic kbh_lanes_t compress(input kbh_lanes_t v, input logic [63:0] m);
		kbh_lanes_t r;
		r = v;
		r.v3 = r.v3 ^ m;
		r = sip_round(r);
		r.v0 = r.v0 ^ m;
		return r;
	endfunction

	function automatic kbh_lanes_t init_lanes(input logic [63:0] k0, input logic [63:0] k1);
		kbh_lanes_t r;
		r.v0 = SIP_C0 ^ k0;
		r.v1 = SIP_C1 ^ k1;
		r.v2 = SIP_C2 ^ k0;
		r.v3 = SIP_C3 ^ k1;
		return r;
	endfunction

	// keep the first cnt bytes, zero the rest
	function automatic logic [63:0] tail_bytes(input logic [63:0] w, input logic [3:0] cnt);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < cnt) begin
				r[8*i +: 8] = w[8*i +: 8];
			end
		end
		return r;
	endfunction

endpackage

/* hw/rtl/kbh_front.sv */
// ----------------------------------------------------------------------------
// kbh_front
// Takes message words, runs one compression per word and builds the length
// block; pushes the padded final lane state into the queue.
// ----------------------------------------------------------------------------
module kbh_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [63:0]       key_low,
	input  logic [63:0]       key_high,
	input  logic [63:0]       message_word,
	input  logic [3:0]        byte_count,
	input  logic              last_word,
	input  logic              word_valid,
	output logic              word_ready,
	input  logic              queue_full,
	output logic              push,
	output kbh_pkg::kbh_lanes_t push_data
);
	import kbh_pkg::*;

	kbh_lanes_t  lanes_q;
	logic [63:0] tail_q;
	logic [7:0]  len_q;
	logic        start_q;
	logic        pend_q;

	logic        accept;
	logic        full_last;
	logic [3:0]  cnt_sat;
	logic [7:0]  len_base;
	logic [7:0]  len_next;
	kbh_lanes_t  v_in;
	logic [63:0] m_in;
	kbh_lanes_t  v_c;

	assign word_ready = !pend_q && !queue_full;
	assign accept     = word_valid && word_ready;
	assign full_last  = byte_count[3];
	assign cnt_sat    = full_last ? 4'd8 : byte_count;
	assign len_base   = start_q ? 8'd0 : len_q;
	assign len_next   = len_base + (last_word ? {4'd0, cnt_sat} : 8'd8);

	always_comb begin
		if (pend_q) begin
			v_in = lanes_q;
			m_in = tail_q;
		end else begin
			v_in = start_q ? init_lanes(key_low, key_high) : lanes_q;
			if (last_word && !full_last) begin
				m_in = tail_bytes(message_word, cnt_sat) | {len_next, 56'd0};
			end else begin
				m_in = message_word;
			end
		end
		v_c = compress(v_in, m_in);
		push_data    = v_c;
		push_data.v2 = v_c.v2 ^ FINAL_XOR;
	end

	assign push = pend_q || (accept && last_word && !full_last);

	always_ff @(posedge clk) begin
		if (accept) begin
			lanes_q <= v_c;
			tail_q  <= {len_next, 56'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= 8'd0;
			start_q <= 1'b1;
			pend_q  <= 1'b0;
		end else if (pend_q) begin
			pend_q  <= 1'b0;
			start_q <= 1'b1;
		end else if (accept) begin
			len_q <= len_next;
			if (last_word && full_last) begin
				pend_q  <= 1'b1;
				start_q <= 1'b0;
			end else begin
				start_q <= last_word;
			end
		end
	end

endmodule

/* hw/rtl/kbh_queue.sv */
// ----------------------------------------------------------------------------
// kbh_queue
// Small FIFO of lane states between the compression front and finalizer.
// ----------------------------------------------------------------------------
module kbh_queue #(
	parameter int DEPTH = kbh_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  kbh_pkg::kbh_lanes_t push_data,
	output logic                full,
	input  logic                pop,
	output kbh_pkg::kbh_lanes_t pop_data,
	output logic                empty
);
	import kbh_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	kbh_lanes_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/kbh_back.sv */
// ----------------------------------------------------------------------------
// kbh_back
// Finalizer: three SipRounds, lane fold, fmix64 with split 32-bit products,
// bucket masking and the output register.
// ----------------------------------------------------------------------------
module kbh_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [4:0]          capacity_log2,
	input  logic                queue_empty,
	input  kbh_pkg::kbh_lanes_t queue_data,
	output logic                pop,
	output logic [63:0]         sip_value,
	output logic [63:0]         mixed_hash,
	output logic [30:0]         bucket_index,
	output logic                hash_valid,
	input  logic                hash_ready
);
	import kbh_pkg::*;

	typedef enum logic [6:0] {
		B_IDLE  = 7'b0000001,
		B_ROUND = 7'b0000010,
		B_FOLD  = 7'b0000100,
		B_PLO   = 7'b0001000,
		B_PX1   = 7'b0010000,
		B_PX2   = 7'b0100000,
		B_SUM   = 7'b1000000
	} back_state_t;

	back_state_t state_q;
	logic [1:0]  rnd_q;
	logic        pass_q;
	logic        hash_valid_q;

	kbh_lanes_t  lanes_q;
	logic [63:0] x_q;
	logic [63:0] sip_q;
	logic [63:0] plo_q;
	logic [31:0] cross_q;
	logic [63:0] sip_out_q;
	logic [63:0] mix_out_q;
	logic [30:0] bucket_q;

	logic [63:0] mconst;
	logic [63:0] fold;
	logic [63:0] prod;
	logic [63:0] prod_mix;
	logic [63:0] mask;
	logic        out_free;

	assign mconst   = pass_q ? MIX_M2 : MIX_M1;
	assign fold     = lanes_q.v0 ^ lanes_q.v1 ^ lanes_q.v2 ^ lanes_q.v3;
	assign prod     = plo_q + {cross_q, 32'd0};
	assign prod_mix = prod ^ (prod >> 33);
	assign mask     = (64'd1 << capacity_log2) - 64'd1;
	assign out_free = !hash_valid_q || hash_ready;
	assign pop      = (state_q == B_IDLE) && !queue_empty;

	assign hash_valid   = hash_valid_q;
	assign sip_value    = sip_out_q;
	assign mixed_hash   = mix_out_q;
	assign bucket_index = bucket_q;

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!queue_empty) begin
					lanes_q <= queue_data;
				end
			end
			B_ROUND: begin
				lanes_q <= sip_round(lanes_q);
			end
			B_FOLD: begin
				sip_q <= fold;
				x_q   <= fold ^ (fold >> 33);
			end
			B_PLO: begin
				plo_q <= {32'd0, x_q[31:0]} * {32'd0, mconst[31:0]};
			end
			B_PX1: begin
				cross_q <= x_q[31:0] * mconst[63:32];
			end
			B_PX2: begin
				cross_q <= cross_q + x_q[63:32] * mconst[31:0];
			end
			B_SUM: begin
				if (!pass_q) begin
					x_q <= prod_mix;
				end else if (out_free) begin
					sip_out_q <= sip_q;
					mix_out_q <= prod_mix;
					bucket_q  <= prod_mix[30:0] & mask[30:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			rnd_q        <= 2'd0;
			pass_q       <= 1'b0;
			hash_valid_q <= 1'b0;
		end else begin
			if (hash_valid_q && hash_ready) begin
				hash_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!queue_empty) begin
						rnd_q   <= 2'd0;
						state_q <= B_ROUND;
					end
				end
				B_ROUND: begin
					rnd_q <= rnd_q + 2'd1;
					if (rnd_q == 2'd2) begin
						state_q <= B_FOLD;
					end
				end
				B_FOLD: begin
					pass_q  <= 1'b0;
					state_q <= B_PLO;
				end
				B_PLO: begin
					state_q <= B_PX1;
				end
				B_PX1: begin
					state_q <= B_PX2;
				end
				B_PX2: begin
					state_q <= B_SUM;
				end
				B_SUM: begin
					if (!pass_q) begin
						pass_q  <= 1'b1;
						state_q <= B_PLO;
					end else if (out_free) begin
						hash_valid_q <= 1'b1;
						state_q      <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/keyed_bucket_hash_top.sv */
// ----------------------------------------------------------------------------
// keyed_bucket_hash_top
// Streaming SipHash-1-3 variant with fmix64 mix and power-of-two bucket index.
//
// Input words arrive on word_valid/word_ready, eight little-endian bytes each;
// last_word closes a message and byte_count gives its valid bytes. Each
// message yields one word on hash_valid/hash_ready: sip_value, mixed_hash and
// bucket_index.
// The compression front takes body words and short last words back to back
// while word_ready is high. A last word with eight bytes is compressed as the
// word, then the length block, and word_ready is low meanwhile. The finalizer
// runs three rounds, a fold and two 64-bit products built from three 32x32
// partial products each, then registers the result and raises hash_valid.
// It takes one message at a time, so short messages are paced by it; a
// queue of QUEUE_DEPTH lane states lets the front keep taking words meanwhile.
// If the receiver stalls, the output register holds, the finalizer waits and
// the queue fills; word_ready then drops. Reset clears the key to zero, sets
// capacity_log2 to 5 and empties the queue; the next word starts a message.
// The key is taken at the first word of a message, capacity_log2 when the
// result is registered.
// ----------------------------------------------------------------------------
module keyed_bucket_hash_top #(
	parameter int QUEUE_DEPTH = kbh_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic [63:0] message_word,
	input  logic [3:0]  byte_count,
	input  logic        last_word,
	input  logic        word_valid,
	output logic        word_ready,
	output logic [63:0] sip_value,
	output logic [63:0] mixed_hash,
	output logic [30:0] bucket_index,
	output logic        hash_valid,
	input  logic        hash_ready
);
	import kbh_pkg::*;

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic [4:0]  cap_log2_q;

	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_empty;
	kbh_lanes_t  q_in;
	kbh_lanes_t  q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= 64'd0;
			key_high_q <= 64'd0;
			cap_log2_q <= CAP_LOG2_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_CAP_LOG2: cap_log2_q <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	kbh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_low      (key_low_q),
		.key_high     (key_high_q),
		.message_word (message_word),
		.byte_count   (byte_count),
		.last_word    (last_word),
		.word_valid   (word_valid),
		.word_ready   (word_ready),
		.queue_full   (q_full),
		.push         (q_push),
		.push_data    (q_in)
	);

	kbh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	kbh_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.capacity_log2 (cap_log2_q),
		.queue_empty   (q_empty),
		.queue_data    (q_out),
		.pop           (q_pop),
		.sip_value     (sip_value),
		.mixed_hash    (mixed_hash),
		.bucket_index  (bucket_index),
		.hash_valid    (hash_valid),
		.hash_ready    (hash_ready)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (!q_full || q_pop))
		else $error("lane state pushed into full queue");

	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		word_ready |-> !q_full)
		else $error("word_ready high while queue full");

	a_bucket_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(hash_valid && (cap_log2_q != 5'd31)) |->
			((bucket_index >> cap_log2_q) == 31'd0))
		else $error("bucket_index outside configured table size");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for keyed_bucket_hash_top. Streams key messages through
// the word handshake and predicts each hash word with an in-bench SipHash-1-3
// variant, fmix64 and bucket mask. Covers directed corner cases, register
// settings (key change mid-message, unused index, capacity extremes), output
// back-pressure, and randomized message streams with idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb_top;

	import kbh_pkg::*;

	localparam logic [1:0] REG_UNUSED     = 2'd3;
	localparam int         SETTLE_CYCLES  = 40;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         LONG_HOLD      = 300;
	localparam int         RANDOM_WORDS   = 520;
	localparam int         CALM_WORDS     = 100;

	typedef struct packed {
		logic [63:0] l0;
		logic [63:0] l1;
		logic [63:0] l2;
		logic [63:0] l3;
	} sip_lanes_t;

	typedef struct {
		logic [63:0] sip;
		logic [63:0] mix;
		logic [30:0] bucket;
	} hash_word_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_we       = 1'b0;
	logic [1:0]  cfg_index    = '0;
	logic [63:0] cfg_data     = '0;
	logic [63:0] message_word = '0;
	logic [3:0]  byte_count   = '0;
	logic        last_word    = 1'b0;
	logic        word_valid   = 1'b0;
	logic        word_ready;
	logic [63:0] sip_value;
	logic [63:0] mixed_hash;
	logic [30:0] bucket_index;
	logic        hash_valid;
	logic        hash_ready   = 1'b0;

	// bench copy of the hashing state and registers
	sip_lanes_t  lanes;
	logic [7:0]  msg_bytes    = '0;
	logic        at_msg_start = 1'b1;
	logic [63:0] key_lo       = '0;
	logic [63:0] key_hi       = '0;
	logic [4:0]  cap_log2     = CAP_LOG2_RESET;

	hash_word_t  pending_hashes[$];
	int          mismatches   = 0;
	int          words_sent   = 0;
	int          hold_request = 0;
	bit          src_gaps     = 1'b0;
	bit          sink_gaps    = 1'b0;

	keyed_bucket_hash_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.message_word(message_word),
		.byte_count  (byte_count),
		.last_word   (last_word),
		.word_valid  (word_valid),
		.word_ready  (word_ready),
		.sip_value   (sip_value),
		.mixed_hash  (mixed_hash),
		.bucket_index(bucket_index),
		.hash_valid  (hash_valid),
		.hash_ready  (hash_ready)
	);

	always #2 clk = ~clk;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int n);
		return (x << n) | (x >> (64 - n));
	endfunction

	function automatic sip_lanes_t lane_round(input sip_lanes_t s);
		sip_lanes_t r;
		r = s;
		r.l0 = r.l0 + r.l1;
		r.l2 = r.l2 + r.l3;
		r.l1 = rotl(r.l1, 13);
		r.l3 = rotl(r.l3, 16);
		r.l1 = r.l1 ^ r.l0;
		r.l3 = r.l3 ^ r.l2;
		r.l0 = rotl(r.l0, 32);
		r.l2 = r.l2 + r.l1;
		r.l0 = r.l0 + r.l3;
		r.l1 = rotl(r.l1, 17);
		r.l3 = rotl(r.l3, 21);
		r.l1 = r.l1 ^ r.l2;
		r.l3 = r.l3 ^ r.l0;
		r.l2 = rotl(r.l2, 32);
		return r;
	endfunction

	function automatic sip_lanes_t lane_absorb(input sip_lanes_t s, input logic [63:0] m);
		sip_lanes_t r;
		r = s;
		r.l3 = r.l3 ^ m;
		r = lane_round(r);
		r.l0 = r.l0 ^ m;
		return r;
	endfunction

	function automatic logic [63:0] fmix64_of(input logic [63:0] v);
		logic [63:0] x;
		x = v;
		x = x ^ (x >> 33);
		x = x * MIX_M1;
		x = x ^ (x >> 33);
		x = x * MIX_M2;
		x = x ^ (x >> 33);
		return x;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// advance the bench hash state by one accepted word
	task automatic track_word(input logic [63:0] w, input logic [3:0] cnt, input logic last);
		logic [63:0] tail;
		logic [63:0] sip;
		logic [63:0] mix;
		logic [63:0] mask;
		logic [3:0]  n;
		hash_word_t  e;
		if (at_msg_start) begin
			lanes.l0 = SIP_C0 ^ key_lo;
			lanes.l1 = SIP_C1 ^ key_hi;
			lanes.l2 = SIP_C2 ^ key_lo;
			lanes.l3 = SIP_C3 ^ key_hi;
			msg_bytes = '0;
			at_msg_start = 1'b0;
		end
		if (!last) begin
			lanes = lane_absorb(lanes, w);
			msg_bytes = msg_bytes + 8'd8;
			return;
		end
		n = (cnt > 4'd8) ? 4'd8 : cnt;
		tail = '0;
		if (n == 4'd8) begin
			lanes = lane_absorb(lanes, w);
		end else begin
			for (int i = 0; i < 8; i++) begin
				if (i < n) begin
					tail[8*i +: 8] = w[8*i +: 8];
				end
			end
		end
		msg_bytes = msg_bytes + 8'(n);
		tail[63:56] = msg_bytes;
		lanes = lane_absorb(lanes, tail);
		lanes.l2 = lanes.l2 ^ FINAL_XOR;
		repeat (3) lanes = lane_round(lanes);
		sip = lanes.l0 ^ lanes.l1 ^ lanes.l2 ^ lanes.l3;
		mix = fmix64_of(sip);
		mask = (64'd1 << cap_log2) - 64'd1;
		e.sip = sip;
		e.mix = mix;
		e.bucket = 31'(mix & mask);
		pending_hashes.push_back(e);
		at_msg_start = 1'b1;
	endtask

	task automatic report_mismatch(input string msg);
		if (mismatches < 200) begin
			$display("MISMATCH @%0t: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	task automatic check_hash();
		hash_word_t e;
		if (pending_hashes.size() == 0) begin
			report_mismatch("hash word with nothing pending");
			return;
		end
		e = pending_hashes.pop_front();
		if (sip_value !== e.sip) begin
			report_mismatch($sformatf("sip_value %h, want %h", sip_value, e.sip));
		end
		if (mixed_hash !== e.mix) begin
			report_mismatch($sformatf("mixed_hash %h, want %h", mixed_hash, e.mix));
		end
		if (bucket_index !== e.bucket) begin
			report_mismatch($sformatf("bucket_index %h, want %h", bucket_index, e.bucket));
		end
	endtask

	task automatic send_word(input logic [63:0] w, input logic [3:0] cnt, input logic last);
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			word_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		word_valid   <= 1'b1;
		message_word <= w;
		byte_count   <= cnt;
		last_word    <= last;
		@(posedge clk);
		while (!word_ready) @(posedge clk);
		track_word(w, cnt, last);
		words_sent++;
	endtask

	function automatic logic [3:0] random_last_count();
		if ($urandom_range(0, 7) == 0) begin
			return 4'($urandom_range(9, 15));
		end
		return 4'($urandom_range(0, 8));
	endfunction

	task automatic send_message(input int body_words, input logic [3:0] cnt);
		for (int i = 0; i < body_words; i++) begin
			send_word(rand64(), 4'($urandom_range(0, 15)), 1'b0);
		end
		send_word(rand64(), cnt, 1'b1);
	endtask

	// drop valid, let every pending hash word arrive, then let the pipe settle
	task automatic drain_results();
		word_valid <= 1'b0;
		@(posedge clk);
		while (pending_hashes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_KEY_LOW:  key_lo = data;
			REG_KEY_HIGH: key_hi = data;
			REG_CAP_LOG2: cap_log2 = data[4:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed();
		send_word(rand64(), 4'd0, 1'b1);          // empty message
		send_word('1, 4'd1, 1'b1);
		send_word('1, 4'd7, 1'b1);
		send_word('1, 4'd8, 1'b1);                // full last word
		send_word(rand64(), 4'd15, 1'b1);         // count saturates
		send_word(rand64(), 4'd9, 1'b1);
		send_word('1, 4'd15, 1'b0);               // body count ignored
		send_word('0, 4'd3, 1'b1);
		send_word('0, 4'd0, 1'b0);
		send_word('1, 4'd8, 1'b1);
		send_word(rand64(), 4'd4, 1'b0);
		send_word(rand64(), 4'd4, 1'b0);
		send_word(rand64(), 4'd4, 1'b1);
		send_word(rand64(), 4'd5, 1'b0);
		send_word(rand64(), 4'd6, 1'b0);
		send_word(rand64(), 4'd2, 1'b1);
		drain_results();
	endtask

	task automatic test_registers();
		write_reg(REG_KEY_LOW, '1);
		write_reg(REG_KEY_HIGH, 64'h0123456789abcdef);
		write_reg(REG_CAP_LOG2, 64'd31);
		send_message(1, 4'd6);
		drain_results();
		write_reg(REG_CAP_LOG2, 64'd0);
		send_message(0, 4'd8);
		drain_results();
		write_reg(REG_UNUSED, rand64());
		send_message(2, 4'd1);
		drain_results();
		write_reg(REG_KEY_LOW, '0);
		write_reg(REG_KEY_HIGH, '1);
		write_reg(REG_CAP_LOG2, 64'd16);
		send_message(1, 4'd3);
		drain_results();
		// new key arrives mid-message; it applies from the next message on
		send_word(rand64(), 4'd8, 1'b0);
		send_word(rand64(), 4'd2, 1'b0);
		drain_results();
		write_reg(REG_KEY_LOW, rand64());
		write_reg(REG_KEY_HIGH, rand64());
		send_word(rand64(), 4'd0, 1'b0);
		send_word(rand64(), 4'd5, 1'b1);
		send_message(0, 4'd7);
		drain_results();
	endtask

	task automatic test_backpressure();
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		hold_request = LONG_HOLD;
		for (int i = 0; i < 30; i++) begin
			send_message(0, random_last_count());
		end
		drain_results();
	endtask

	task automatic test_random();
		int phase;
		int goal;
		int r;
		phase = 0;
		while (words_sent < RANDOM_WORDS) begin
			src_gaps  = (words_sent < RANDOM_WORDS - CALM_WORDS) && (phase != 3);
			sink_gaps = (words_sent < RANDOM_WORDS - CALM_WORDS) && (phase != 5);
			case (phase % 4)
				0: write_reg(REG_KEY_LOW, '0);
				1: write_reg(REG_KEY_LOW, '1);
				default: write_reg(REG_KEY_LOW, rand64());
			endcase
			write_reg(REG_KEY_HIGH, (phase % 5 == 1) ? '1 : rand64());
			case (phase % 3)
				0: write_reg(REG_CAP_LOG2, (rand64() & ~64'h1f) | 64'h1f);
				1: write_reg(REG_CAP_LOG2, rand64() & ~64'h1f);
				default: write_reg(REG_CAP_LOG2, rand64());
			endcase
			goal = words_sent + 48;
			while (words_sent < goal) begin
				r = $urandom_range(0, 9);
				if (r < 6) begin
					send_message($urandom_range(0, 2), random_last_count());
				end else if (r < 9) begin
					send_message($urandom_range(3, 8), random_last_count());
				end else begin
					send_message($urandom_range(9, 40), random_last_count());
				end
			end
			drain_results();
			phase++;
		end
	endtask

	initial begin : hash_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hash_valid && hash_ready) begin
				check_hash();
			end
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end else if (stall_left == 0 && sink_gaps && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 17);
			end
			if (stall_left > 0) begin
				hash_ready <= 1'b0;
				stall_left--;
			end else begin
				hash_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((word_valid && word_ready) || (hash_valid && hash_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		lanes = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
		test_directed();
		test_registers();
		test_backpressure();
		test_random();
		if (pending_hashes.size() != 0) begin
			report_mismatch($sformatf("%0d hash words never arrived", pending_hashes.size()));
		end
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
